/* design/iirdf2_pkg.sv */
// shared constants, types and helper functions for the direct form ii iir filter core
// no dependencies; used by the interfaces and every module of the block
package iirdf2_pkg;

   localparam int TAPS      = 3;
   localparam int FF_REGS   = 3;
   localparam int FB_REGS   = 2;
   localparam int COEF_W    = 18;
   localparam int FRAC_W    = 14;
   localparam int SAMPLE_W  = 16;
   localparam int W_W       = 32;
   localparam int PROD_W    = COEF_W + W_W;
   localparam int ACC_W     = PROD_W + $clog2(TAPS + 1);
   localparam int RQ_W      = ACC_W - FRAC_W;
   localparam int K_W       = $clog2(TAPS);
   localparam int DL_DEPTH  = TAPS - 1;
   localparam int DL_IDX_W  = (TAPS > 2) ? $clog2(TAPS - 1) : 1;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FF_COEF_0 = 3'd0,
      CSR_FF_COEF_1 = 3'd1,
      CSR_FF_COEF_2 = 3'd2,
      CSR_FB_COEF_1 = 3'd3,
      CSR_FB_COEF_2 = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_FB,
      SEQ_FB_DRAIN,
      SEQ_ROUND_W,
      SEQ_FF,
      SEQ_FF_DRAIN,
      SEQ_ROUND_Y
   } seq_state_type;

   typedef struct packed {
      logic issue;
      logic sub;
      logic load;
   } mac_ctrl_type;

   typedef struct packed {
      logic [FF_REGS-1:0][COEF_W-1:0] ff;
      logic [FB_REGS-1:0][COEF_W-1:0] fb;
   } coef_set_type;

   // b0 at unity, every other coefficient zero
   localparam coef_set_type COEF_RESET = '{
      ff: {{(FF_REGS-1){COEF_W'(0)}}, COEF_ONE},
      fb: '0
   };

   // feedforward coefficient b_k, zero where no register exists
   function automatic logic signed [COEF_W-1:0] ff_pick(coef_set_type c, logic [K_W-1:0] k);
      logic signed [COEF_W-1:0] r;
      r = '0;
      for (int i = 0; i < FF_REGS; i++) begin
         if (i == int'(k)) r = c.ff[i];
      end
      return r;
   endfunction

   // feedback coefficient a_k, k from one
   function automatic logic signed [COEF_W-1:0] fb_pick(coef_set_type c, logic [K_W-1:0] k);
      logic signed [COEF_W-1:0] r;
      r = '0;
      for (int i = 0; i < FB_REGS; i++) begin
         if (i + 1 == int'(k)) r = c.fb[i];
      end
      return r;
   endfunction

   // divide by 2^FRAC_W, round to nearest, ties toward plus infinity
   function automatic logic signed [RQ_W-1:0] round_q(logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      t = a + ACC_W'(1 << (FRAC_W - 1));
      return RQ_W'(t >>> FRAC_W);
   endfunction

   function automatic logic signed [W_W-1:0] sat_w(logic signed [RQ_W-1:0] r);
      logic signed [RQ_W-1:0] hi;
      logic signed [RQ_W-1:0] lo;
      hi = {{(RQ_W-W_W+1){1'b0}}, {(W_W-1){1'b1}}};
      lo = {{(RQ_W-W_W+1){1'b1}}, {(W_W-1){1'b0}}};
      if (r > hi) return hi[W_W-1:0];
      if (r < lo) return lo[W_W-1:0];
      return r[W_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_y(logic signed [RQ_W-1:0] r);
      logic signed [RQ_W-1:0] hi;
      logic signed [RQ_W-1:0] lo;
      hi = {{(RQ_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
      lo = {{(RQ_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
      if (r > hi) return hi[SAMPLE_W-1:0];
      if (r < lo) return lo[SAMPLE_W-1:0];
      return r[SAMPLE_W-1:0];
   endfunction

endpackage

/* design/iirdf2_if.sv */
// request, response and register write channels of the iir filter core
// depends on iirdf2_pkg for field widths
interface iirdf2_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [iirdf2_pkg::SAMPLE_W-1:0]  sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirdf2_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [iirdf2_pkg::SAMPLE_W-1:0]  sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface iirdf2_csr_if;
   logic                                    valid;
   logic                                    ready;
   logic [iirdf2_pkg::CSR_IDX_W-1:0]        index;
   logic [iirdf2_pkg::COEF_W-1:0]           data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/iirdf2_mac.sv */
// shared multiply-accumulate unit: one registered coefficient-by-state product per cycle
// depends on iirdf2_pkg
module iirdf2_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  iirdf2_pkg::mac_ctrl_type               ctrl,
   input  logic signed [iirdf2_pkg::ACC_W-1:0]    load_value,
   input  logic signed [iirdf2_pkg::COEF_W-1:0]   coef,
   input  logic signed [iirdf2_pkg::W_W-1:0]      data,
   output logic signed [iirdf2_pkg::ACC_W-1:0]    acc
);

   logic signed [iirdf2_pkg::PROD_W-1:0] prod_in;
   logic signed [iirdf2_pkg::PROD_W-1:0] prod_ff;
   logic                                 prod_vld_ff;
   logic                                 prod_sub_ff;
   logic signed [iirdf2_pkg::ACC_W-1:0]  acc_in;
   logic signed [iirdf2_pkg::ACC_W-1:0]  acc_ff;
   logic signed [iirdf2_pkg::ACC_W-1:0]  prod_ext;

   assign prod_in  = coef * data;
   assign prod_ext = iirdf2_pkg::ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = load_value;
      end else if (prod_vld_ff) begin
         acc_in = prod_sub_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_sub_ff <= ctrl.sub;
      acc_ff      <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* design/iirdf2_seq.sv */
// sequencer: walks the feedback then feedforward taps through the shared mac,
// rounds and saturates w and y, holds the delay line and the response register
// depends on iirdf2_pkg and iirdf2_if
module iirdf2_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   iirdf2_req_if.sink                             req_ch,
   iirdf2_rsp_if.source                           rsp_ch,
   input  iirdf2_pkg::coef_set_type               coefs,
   output iirdf2_pkg::mac_ctrl_type               mac_ctrl,
   output logic signed [iirdf2_pkg::ACC_W-1:0]    mac_load_value,
   output logic signed [iirdf2_pkg::COEF_W-1:0]   mac_coef,
   output logic signed [iirdf2_pkg::W_W-1:0]      mac_data,
   input  logic signed [iirdf2_pkg::ACC_W-1:0]    mac_acc
);

   iirdf2_pkg::seq_state_type                state_ff, state_in;
   logic [iirdf2_pkg::K_W-1:0]               k_ff, k_in, k_minus;
   logic [iirdf2_pkg::DL_IDX_W-1:0]          dl_idx;
   logic signed [iirdf2_pkg::W_W-1:0]        dl_ff [iirdf2_pkg::DL_DEPTH];
   logic signed [iirdf2_pkg::W_W-1:0]        dl_rd;
   logic                                     dl_shift;
   logic signed [iirdf2_pkg::W_W-1:0]        w_ff, w_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [iirdf2_pkg::SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                                     accept;
   logic                                     out_free;
   logic                                     last_tap;
   logic signed [iirdf2_pkg::ACC_W-1:0]      x_scaled;

   assign req_ch.ready      = (state_ff == iirdf2_pkg::SEQ_IDLE);
   assign accept            = req_ch.valid && req_ch.ready;
   assign out_free          = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_data_ff;

   assign k_minus  = k_ff - iirdf2_pkg::K_W'(1);
   assign dl_idx   = k_minus[iirdf2_pkg::DL_IDX_W-1:0];
   assign dl_rd    = dl_ff[dl_idx];
   assign last_tap = (k_ff == iirdf2_pkg::K_W'(iirdf2_pkg::TAPS - 1));
   assign x_scaled = iirdf2_pkg::ACC_W'(req_ch.sample_in) <<< iirdf2_pkg::FRAC_W;

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      w_in           = w_ff;
      dl_shift       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in    = rsp_data_ff;
      mac_ctrl       = '0;
      mac_load_value = '0;
      mac_coef       = '0;
      mac_data       = '0;
      case (state_ff)
         iirdf2_pkg::SEQ_IDLE: begin
            // accumulator starts at x scaled to the coefficient fraction
            mac_load_value = x_scaled;
            if (accept) begin
               mac_ctrl.load = 1'b1;
               k_in          = iirdf2_pkg::K_W'(1);
               state_in      = iirdf2_pkg::SEQ_FB;
            end
         end
         iirdf2_pkg::SEQ_FB: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.sub   = 1'b1;
            mac_coef       = iirdf2_pkg::fb_pick(coefs, k_ff);
            mac_data       = dl_rd;
            if (last_tap) begin
               state_in = iirdf2_pkg::SEQ_FB_DRAIN;
            end else begin
               k_in = k_ff + iirdf2_pkg::K_W'(1);
            end
         end
         iirdf2_pkg::SEQ_FB_DRAIN: begin
            state_in = iirdf2_pkg::SEQ_ROUND_W;
         end
         iirdf2_pkg::SEQ_ROUND_W: begin
            w_in     = iirdf2_pkg::sat_w(iirdf2_pkg::round_q(mac_acc));
            k_in     = '0;
            state_in = iirdf2_pkg::SEQ_FF;
         end
         iirdf2_pkg::SEQ_FF: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.load  = (k_ff == '0);
            mac_coef       = iirdf2_pkg::ff_pick(coefs, k_ff);
            mac_data       = (k_ff == '0) ? w_ff : dl_rd;
            if (last_tap) begin
               state_in = iirdf2_pkg::SEQ_FF_DRAIN;
            end else begin
               k_in = k_ff + iirdf2_pkg::K_W'(1);
            end
         end
         iirdf2_pkg::SEQ_FF_DRAIN: begin
            state_in = iirdf2_pkg::SEQ_ROUND_Y;
         end
         iirdf2_pkg::SEQ_ROUND_Y: begin
            // hold here until the response register can take y
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = iirdf2_pkg::sat_y(iirdf2_pkg::round_q(mac_acc));
               dl_shift     = 1'b1;
               state_in     = iirdf2_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = iirdf2_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iirdf2_pkg::SEQ_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < iirdf2_pkg::DL_DEPTH; i++) begin
            dl_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (dl_shift) begin
            for (int i = iirdf2_pkg::DL_DEPTH - 1; i > 0; i--) begin
               dl_ff[i] <= dl_ff[i-1];
            end
            dl_ff[0] <= w_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_starts_feedback: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == iirdf2_pkg::SEQ_FB)
      else $error("accepted request did not start the feedback pass");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iirdf2_pkg::SEQ_ROUND_Y && !out_free)
      |=> (state_ff == iirdf2_pkg::SEQ_ROUND_Y && rsp_valid_ff))
      else $error("result left round state while response register was full");

   a_response_from_round: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == iirdf2_pkg::SEQ_ROUND_Y))
      else $error("response raised outside the output round state");

   a_load_only_at_pass_start: assert property (@(posedge clock) disable iff (reset)
      mac_ctrl.load |-> (state_ff == iirdf2_pkg::SEQ_IDLE || state_ff == iirdf2_pkg::SEQ_FF))
      else $error("accumulator load outside the start of a pass");

endmodule

/* design/iir_direct_form_two_filter_core.sv */
// Direct form II IIR filter core for 16-bit signed audio samples, one filtered sample per
// request, with Q4.14 coefficients written through the register channel. All products
// go through one 18x32 multiplier, so a request passes from acceptance through an
// accumulator load, TAPS-1 feedback products, TAPS feedforward products, and a drain
// and a rounding step after each pass before the core can accept again. The request
// channel is not ready during that time; a finished sample waits in the response
// register, and the next request is accepted meanwhile. If the previous sample is
// still waiting when the next one is rounded, the core holds in its rounding cycle
// until the response is taken.
// The intermediate value saturates to 32 bits and the output to 16 bits. Write registers
// only while the core is idle; writes to unknown indexes are dropped.
// depends on iirdf2_pkg, iirdf2_if, iirdf2_mac and iirdf2_seq
module iir_direct_form_two_filter_core (
   input  logic          clock,
   input  logic          reset,
   iirdf2_req_if.sink    req_ch,
   iirdf2_rsp_if.source  rsp_ch,
   iirdf2_csr_if.sink    csr_ch
);

   iirdf2_pkg::coef_set_type                   coefs_ff;
   iirdf2_pkg::mac_ctrl_type                   mac_ctrl;
   logic signed [iirdf2_pkg::ACC_W-1:0]        mac_load_value;
   logic signed [iirdf2_pkg::COEF_W-1:0]       mac_coef;
   logic signed [iirdf2_pkg::W_W-1:0]          mac_data;
   logic signed [iirdf2_pkg::ACC_W-1:0]        mac_acc;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= iirdf2_pkg::COEF_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            iirdf2_pkg::CSR_FF_COEF_0: coefs_ff.ff[0] <= csr_ch.data;
            iirdf2_pkg::CSR_FF_COEF_1: coefs_ff.ff[1] <= csr_ch.data;
            iirdf2_pkg::CSR_FF_COEF_2: coefs_ff.ff[2] <= csr_ch.data;
            iirdf2_pkg::CSR_FB_COEF_1: coefs_ff.fb[0] <= csr_ch.data;
            iirdf2_pkg::CSR_FB_COEF_2: coefs_ff.fb[1] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   iirdf2_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .coefs          (coefs_ff),
      .mac_ctrl       (mac_ctrl),
      .mac_load_value (mac_load_value),
      .mac_coef       (mac_coef),
      .mac_data       (mac_data),
      .mac_acc        (mac_acc)
   );

   iirdf2_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .load_value (mac_load_value),
      .coef       (mac_coef),
      .data       (mac_data),
      .acc        (mac_acc)
   );

endmodule
